/* rtl/tsrq_pkg.sv */
// Shared constants, codes and control types of the task slot ready queue.
`timescale 1ns / 1ps
`default_nettype none
package tsrq_pkg;

  localparam int NUM_SLOTS = 128;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int GRP_W     = 8;
  localparam int NUM_GRP   = NUM_SLOTS / GRP_W;
  localparam int GRP_SEL_W = $clog2(NUM_GRP);
  localparam int GRP_BIT_W = $clog2(GRP_W);
  localparam int STATUS_W  = 3;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_BLOCK  = 2'd2,
    ACT_WAKE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BADSLOT = 3'd2,
    ST_NOTBLK  = 3'd3,
    ST_NOTRUN  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_EXEC   = 3'd2,
    S_UNLINK = 3'd3,
    S_OUT    = 3'd4
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic unlink;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_unlink;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/tsrq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tsrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/tsrq_ctrl.sv */
// Sequencing state machine of the task slot ready queue.
`timescale 1ns / 1ps
`default_nettype none
module tsrq_ctrl
  import tsrq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  output      logic     out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_sts_t  sts_i,
  output      ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   state_d = S_EXEC;
      S_EXEC:   state_d = sts_i.need_unlink ? S_UNLINK : S_OUT;
      S_UNLINK: state_d = S_OUT;
      S_OUT:    if (!out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.unlink = (state_q == S_UNLINK);
  end

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_UNLINK))
    else $error("result beat without execution");
  a_unlink_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.unlink |-> $past(state_q) == S_EXEC)
    else $error("unlink out of sequence");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule
`default_nettype wire

/* rtl/tsrq_dp.sv */
// Datapath: slot table, ready queue links, blocked set and running task.
`timescale 1ns / 1ps
`default_nettype none
module tsrq_dp
  import tsrq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_cmd_t            cmd_i,
  output      dp_sts_t             sts_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [SLOT_W-1:0]   task_id_i,
  output      logic [STATUS_W-1:0] status_o,
  output      logic [SLOT_W-1:0]   slot_given_o,
  output      logic [SLOT_W-1:0]   running_slot_o,
  output      logic                running_is_idle_o
);

  action_e                action_q;
  logic [SLOT_W-1:0]      id_q;
  logic [NUM_SLOTS-1:0]   used_q, used_d, ready_q, ready_d, blocked_q, blocked_d;
  logic [SLOT_W-1:0]      head_q, head_d, tail_q, tail_d, running_q, running_d;
  logic                   empty_q, empty_d, idle_q, idle_d;
  logic [SLOT_W-1:0]      sel_q, sel_d, given_q, given_d;
  status_e                status_q, status_d;
  logic [NUM_GRP-1:0]     grp_free_q, grp_free_d;
  logic [GRP_BIT_W-1:0]   grp_idx_q [NUM_GRP];
  logic [GRP_BIT_W-1:0]   grp_idx_d [NUM_GRP];

  logic                   nx_we, pv_we;
  logic [SLOT_W-1:0]      nx_waddr, nx_wdata, pv_waddr, pv_wdata, rd_addr;
  logic [SLOT_W-1:0]      nx_rdata, pv_rdata;

  logic                   found;
  logic [GRP_SEL_W-1:0]   fgrp;
  logic [SLOT_W-1:0]      free_slot, enq_slot;
  logic                   do_enq, new_empty;
  logic [SLOT_W-1:0]      new_head;

  // Group scan: one free flag and first free index per group of slots.
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_free_d[g] = ~&used_q[g*GRP_W +: GRP_W];
      grp_idx_d[g]  = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!used_q[g*GRP_W + b]) grp_idx_d[g] = GRP_BIT_W'(b);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    fgrp  = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        found = 1'b1;
        fgrp  = GRP_SEL_W'(g);
      end
    end
    free_slot = SLOT_W'({fgrp, grp_idx_q[fgrp]});
  end

  assign rd_addr = (action_q == ACT_BLOCK) ? running_q : id_q;

  always_comb begin
    used_d    = used_q;
    ready_d   = ready_q;
    blocked_d = blocked_q;
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    running_d = running_q;
    idle_d    = idle_q;
    sel_d     = sel_q;
    given_d   = given_q;
    status_d  = status_q;
    nx_we     = 1'b0;
    pv_we     = 1'b0;
    nx_waddr  = tail_q;
    nx_wdata  = '0;
    pv_waddr  = '0;
    pv_wdata  = tail_q;
    sts_o.need_unlink = 1'b0;
    do_enq    = 1'b0;
    enq_slot  = (action_q == ACT_CREATE) ? free_slot : id_q;
    new_empty = empty_q;
    new_head  = head_q;

    if (cmd_i.exec) begin
      status_d = ST_OK;
      given_d  = id_q;
      case (action_q)
        ACT_CREATE: begin
          given_d = '0;
          if (!found) begin
            status_d = ST_FULL;
          end else begin
            used_d[free_slot]    = 1'b1;
            blocked_d[free_slot] = 1'b0;
            given_d = free_slot;
            do_enq  = 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (!used_q[id_q]) begin
            status_d = ST_BADSLOT;
          end else begin
            blocked_d[id_q] = 1'b0;
            used_d[id_q]    = 1'b0;
            sel_d = id_q;
            sts_o.need_unlink = 1'b1;
          end
        end
        ACT_BLOCK: begin
          if (idle_q) begin
            status_d = ST_NOTRUN;
            given_d  = '0;
          end else begin
            given_d = running_q;
            blocked_d[running_q] = 1'b1;
            sel_d = running_q;
            sts_o.need_unlink = 1'b1;
          end
        end
        ACT_WAKE: begin
          if (!used_q[id_q]) begin
            status_d = ST_BADSLOT;
          end else if (!blocked_q[id_q]) begin
            status_d = ST_NOTBLK;
          end else begin
            blocked_d[id_q] = 1'b0;
            do_enq = 1'b1;
          end
        end
        default: status_d = ST_OK;
      endcase

      if (do_enq) begin
        if (empty_q) begin
          head_d  = enq_slot;
          empty_d = 1'b0;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = tail_q;
          nx_wdata = enq_slot;
          pv_we    = 1'b1;
          pv_waddr = enq_slot;
          pv_wdata = tail_q;
        end
        tail_d = enq_slot;
        ready_d[enq_slot] = 1'b1;
        if (idle_q) begin
          running_d = enq_slot;
          idle_d    = 1'b0;
        end
      end
    end

    if (cmd_i.unlink) begin
      if (ready_q[sel_q]) begin
        if (sel_q == head_q && sel_q == tail_q) begin
          new_empty = 1'b1;
          new_head  = '0;
          tail_d    = '0;
        end else if (sel_q == head_q) begin
          new_head = nx_rdata;
        end else if (sel_q == tail_q) begin
          tail_d = pv_rdata;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata;
          nx_wdata = nx_rdata;
          pv_we    = 1'b1;
          pv_waddr = nx_rdata;
          pv_wdata = pv_rdata;
        end
        ready_d[sel_q] = 1'b0;
      end
      head_d  = new_head;
      empty_d = new_empty;
      if (!idle_q && running_q == sel_q) begin
        if (new_empty) begin
          idle_d    = 1'b1;
          running_d = '0;
        end else begin
          running_d = new_head;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_e'(action_i);
      id_q     <= task_id_i;
    end
    if (cmd_i.scan) begin
      grp_free_q <= grp_free_d;
      grp_idx_q  <= grp_idx_d;
    end
    sel_q    <= sel_d;
    given_q  <= given_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      ready_q   <= '0;
      blocked_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      empty_q   <= 1'b1;
      running_q <= '0;
      idle_q    <= 1'b1;
    end else begin
      used_q    <= used_d;
      ready_q   <= ready_d;
      blocked_q <= blocked_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      empty_q   <= empty_d;
      running_q <= running_d;
      idle_q    <= idle_d;
    end
  end

  tsrq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (rd_addr),
    .rdata_o (nx_rdata)
  );

  tsrq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pv_rdata)
  );

  assign status_o          = status_q;
  assign slot_given_o      = given_q;
  assign running_slot_o    = running_q;
  assign running_is_idle_o = idle_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> empty_q && running_q == '0)
    else $error("idle while ready queue holds tasks");
  a_running_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_q |-> ready_q[running_q])
    else $error("running task not in ready queue");
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> head_q == '0 && tail_q == '0 && ready_q == '0)
    else $error("empty queue with live links");

endmodule
`default_nettype wire

/* rtl/task_slot_ready_queue_core.sv */
// Top level of the task slot ready queue: controller plus datapath.
// Sequence: accept, group scan, execute, then the result beat (create, wake, errors);
//   remove and block add an unlink state, which relinks through the link RAM read port.
// Next action accepted only after the result beat is taken; the receiver may stall it.
// Reset: asynchronous; all slots free, queue empty, idle running.
// Link RAMs need no clearing pass; entries are written before they are read.
`timescale 1ns / 1ps
`default_nettype none
module task_slot_ready_queue_core
  import tsrq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [SLOT_W-1:0]   task_id_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [STATUS_W-1:0] status_o,
  output      logic [SLOT_W-1:0]   slot_given_o,
  output      logic [SLOT_W-1:0]   running_slot_o,
  output      logic                running_is_idle_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  tsrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsrq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .task_id_i         (task_id_i),
    .status_o          (status_o),
    .slot_given_o      (slot_given_o),
    .running_slot_o    (running_slot_o),
    .running_is_idle_o (running_is_idle_o)
  );

endmodule
`default_nettype wire

/* test/task_slot_ready_queue_core_tb.sv */
// Self-checking testbench of the task slot ready queue: directed and random actions.
`timescale 1ns / 1ps
module task_slot_ready_queue_core_tb;
  import tsrq_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = '0;
  logic [SLOT_W-1:0]   task_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_given_o;
  logic [SLOT_W-1:0]   running_slot_o;
  logic                running_is_idle_o;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   given;
    logic [SLOT_W-1:0]   running;
    logic                idle;
  } sched_res_t;

  task_slot_ready_queue_core u_top (.*);

  initial forever #1 clk_i = ~clk_i;

  // scheduler mirror
  logic              used_q [NUM_SLOTS];
  logic              ready_q [NUM_SLOTS];
  logic              blocked_q [NUM_SLOTS];
  logic [SLOT_W-1:0] nxt_q [NUM_SLOTS];
  logic [SLOT_W-1:0] prv_q [NUM_SLOTS];
  logic [SLOT_W-1:0] head_q, tail_q, run_q;
  logic              empty_q, idle_q;
  int                live_q;

  sched_res_t expected_results[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;

  task automatic enqueue_slot(input logic [SLOT_W-1:0] s);
    if (empty_q) begin
      head_q = s;
      empty_q = 1'b0;
    end else begin
      nxt_q[tail_q] = s;
      prv_q[s] = tail_q;
    end
    tail_q = s;
    ready_q[s] = 1'b1;
    if (idle_q) begin
      run_q = s;
      idle_q = 1'b0;
    end
  endtask

  task automatic unlink_slot(input logic [SLOT_W-1:0] s);
    if (ready_q[s]) begin
      if (s == head_q && s == tail_q) begin
        empty_q = 1'b1;
        head_q = '0;
        tail_q = '0;
      end else if (s == head_q) begin
        head_q = nxt_q[s];
      end else if (s == tail_q) begin
        tail_q = prv_q[s];
      end else begin
        nxt_q[prv_q[s]] = nxt_q[s];
        prv_q[nxt_q[s]] = prv_q[s];
      end
      ready_q[s] = 1'b0;
    end
    if (!idle_q && run_q == s) begin
      if (empty_q) begin
        idle_q = 1'b1;
        run_q = '0;
      end else begin
        run_q = head_q;
      end
    end
  endtask

  function automatic int lowest_free();
    for (int s = 0; s < NUM_SLOTS; s++) if (!used_q[s]) return s;
    return -1;
  endfunction

  task automatic predict_action(input action_e act, input logic [SLOT_W-1:0] id);
    sched_res_t r;
    int         s;
    r.status = ST_OK;
    r.given = id;
    case (act)
      ACT_CREATE: begin
        r.given = '0;
        s = lowest_free();
        if (live_q >= NUM_SLOTS || s < 0) begin
          r.status = ST_FULL;
        end else begin
          used_q[s] = 1'b1;
          blocked_q[s] = 1'b0;
          live_q++;
          enqueue_slot(s[SLOT_W-1:0]);
          r.given = s[SLOT_W-1:0];
        end
      end
      ACT_REMOVE: begin
        if (!used_q[id]) begin
          r.status = ST_BADSLOT;
        end else begin
          unlink_slot(id);
          blocked_q[id] = 1'b0;
          used_q[id] = 1'b0;
          if (live_q > 0) live_q--;
        end
      end
      ACT_BLOCK: begin
        if (idle_q) begin
          r.status = ST_NOTRUN;
          r.given = '0;
        end else begin
          r.given = run_q;
          blocked_q[run_q] = 1'b1;
          unlink_slot(r.given);
          blocked_q[r.given] = 1'b1;
        end
      end
      default: begin
        if (!used_q[id]) r.status = ST_BADSLOT;
        else if (!blocked_q[id]) r.status = ST_NOTBLK;
        else begin
          blocked_q[id] = 1'b0;
          enqueue_slot(id);
        end
      end
    endcase
    r.running = idle_q ? '0 : run_q;
    r.idle = idle_q;
    expected_results.push_back(r);
  endtask

  task automatic send_action(input action_e act, input logic [SLOT_W-1:0] id);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    task_id_i <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_action(act, id);
  endtask

  // result checker
  always @(posedge clk_i) begin
    sched_res_t got, exp_r;
    if (out_valid_o && !out_stall_i) begin
      got = '{status_o, slot_given_o, running_slot_o, running_is_idle_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("task_slot_ready_queue_core_tb: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_action(ACT_BLOCK, 7'd0);
    send_action(ACT_REMOVE, 7'd0);
    send_action(ACT_WAKE, 7'd127);
    send_action(ACT_CREATE, 7'd99);
    send_action(ACT_CREATE, 7'd0);
    send_action(ACT_CREATE, 7'd127);
    send_action(ACT_WAKE, 7'd1);
    send_action(ACT_BLOCK, 7'd127);
    send_action(ACT_WAKE, 7'd0);
    send_action(ACT_REMOVE, 7'd1);
    send_action(ACT_BLOCK, 7'd0);
    send_action(ACT_REMOVE, 7'd2);
    send_action(ACT_REMOVE, 7'd0);
    send_action(ACT_REMOVE, 7'd0);
    send_action(ACT_BLOCK, 7'd0);
    wait_drained();
  endtask

  task automatic test_fill_table();
    for (int i = 0; i < NUM_SLOTS + 2; i++) send_action(ACT_CREATE, 7'($urandom));
    send_action(ACT_REMOVE, 7'd127);
    send_action(ACT_REMOVE, 7'd64);
    send_action(ACT_CREATE, 7'd0);
    send_action(ACT_CREATE, 7'd0);
    send_action(ACT_CREATE, 7'd0);
    for (int i = 0; i < NUM_SLOTS; i++) send_action(ACT_REMOVE, 7'(i));
    wait_drained();
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25 && live_q < 40) send_action(ACT_CREATE, 7'($urandom));
      else if (k < 45) send_action(ACT_BLOCK, 7'($urandom));
      else if (k < 70) send_action(ACT_WAKE, 7'($urandom_range(0, 47)));
      else if (k < 90) send_action(ACT_REMOVE, 7'($urandom_range(0, 47)));
      else send_action(action_e'($urandom_range(0, 3)), 7'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      used_q[i] = 0; ready_q[i] = 0; blocked_q[i] = 0; nxt_q[i] = 0; prv_q[i] = 0;
    end
    head_q = '0; tail_q = '0; run_q = '0; empty_q = 1'b1; idle_q = 1'b1; live_q = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_table();
    test_random(700);
    wait_drained();
    test_random(250);
    quiet = 1'b1;
    test_random(120);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("task_slot_ready_queue_core_tb: PASS");
    else
      $display("task_slot_ready_queue_core_tb: FAIL");
    $finish;
  end

endmodule
